FILE: sv/lsrb_pkg.sv
// Package for the line slot ring buffer: default sizes, action and status codes.
// Used by line_slot_ring_buffer_core; depends on nothing else.
package lsrb_pkg;

   // default store geometry
   localparam int SLOTS_DEF    = 8;
   localparam int SLOT_LEN_DEF = 128;

   // stream bytes with a meaning of their own
   localparam logic [7:0] NEWLINE_BYTE = 8'd10;
   localparam logic [7:0] TERM_BYTE    = 8'd0;

   // request kinds, carried in req_tuser
   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_QUERY = 2'd1,
      ACT_SEEK  = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   // write status codes
   typedef enum logic [2:0] {
      WS_STORED   = 3'd0,
      WS_ENDED    = 3'd1,
      WS_DROP_NEW = 3'd2,
      WS_DROP_OLD = 3'd3,
      WS_DROP_BYTE = 3'd4
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      S_CLEAR = 2'b01,
      S_RUN   = 2'b10
   } state_type;

endpackage

FILE: sv/line_slot_ring_buffer_core.sv
// Line slot ring buffer: cuts a byte stream into lines held in fixed-size slots.
// A response item is registered as its request item is accepted and is offered in the next cycle.
// Throughput: one item per cycle while the response side keeps taking items.
// Reset (synchronous, active high) starts a clearing pass over the store, one word of
// each bank a cycle; no request item is taken until it ends. CSR writes are always taken.
module line_slot_ring_buffer_core
   import lsrb_pkg::*;
#(
   parameter int SLOTS    = SLOTS_DEF,
   parameter int SLOT_LEN = SLOT_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [14:8] read_offset, [15] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] write_status, [3] flag, [11:4] read_data, rest zero
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // clobber_old
);

   // geometry: slot length is padded to a power of two and each slot is split over two banks by parity
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int OFF_W      = $clog2(SLOT_LEN);
   localparam int BANK_AW    = SLOT_W + OFF_W - 1;
   localparam int BANK_DEPTH = SLOTS * (2 ** (OFF_W - 1));
   localparam int OX_W       = (OFF_W > 7) ? OFF_W : 7;

   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [BANK_AW-1:0] LAST_WORD = BANK_AW'(BANK_DEPTH - 1);

   // store banks
   logic [7:0] mem_even [BANK_DEPTH];
   logic [7:0] mem_odd  [BANK_DEPTH];

   // control state
   state_type            state_ff, state_in;
   logic [BANK_AW-1:0]   clr_addr_ff, clr_addr_in;
   logic [SLOT_W-1:0]    wslot_ff, wslot_in;
   logic [SLOT_W-1:0]    rslot_ff, rslot_in;
   logic [OFF_W-1:0]     wlen_ff, wlen_in;
   logic [SLOTS-1:0]     nz_ff, nz_in;      // first byte of slot is nonzero
   logic [SLOTS-1:0]     z0_ff, z0_in;      // first byte of slot reads as zero
   logic                 clobber_ff;

   // response registers
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic                 flag_ff, flag_in;
   logic                 rd_en_ff, rd_en_in;
   logic                 rd_odd_ff, rd_odd_in;
   logic [7:0]           rd_even_ff;
   logic [7:0]           rd_odd_data_ff;

   // request fields
   action_type           act;
   logic [7:0]           data_byte;
   logic [OX_W-1:0]      off_x;
   logic [OFF_W-1:0]     rd_off;
   logic                 off_ok;
   logic                 accept;

   // bank write and read ports
   logic                 we_even, we_odd;
   logic [BANK_AW-1:0]   wa_even, wa_odd;
   logic [7:0]           wd_even, wd_odd;
   logic [BANK_AW-1:0]   ra;

   // helpers
   logic [SLOT_W-1:0]    wnext, rnext;
   logic [OFF_W-1:0]     wlen_p1;
   logic [OFF_W:0]       wlen_p2;

   assign act       = action_type'(req_tuser);
   assign data_byte = req_tdata[7:0];
   assign off_x     = OX_W'(req_tdata[14:8]);
   assign rd_off    = off_x[OFF_W-1:0];
   assign off_ok    = ({1'b0, off_x} < (OX_W + 1)'(SLOT_LEN));

   assign req_tready = (state_ff == S_RUN) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign wnext   = (wslot_ff == LAST_SLOT) ? '0 : wslot_ff + 1'b1;
   assign rnext   = (rslot_ff == LAST_SLOT) ? '0 : rslot_ff + 1'b1;
   assign wlen_p1 = wlen_ff + 1'b1;
   assign wlen_p2 = {1'b0, wlen_ff} + (OFF_W + 1)'(2);
   assign ra      = {rslot_ff, rd_off[OFF_W-1:1]};

   // work out one request item: store writes, pointer moves, response fields
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      wslot_in     = wslot_ff;
      rslot_in     = rslot_ff;
      wlen_in      = wlen_ff;
      nz_in        = nz_ff;
      z0_in        = z0_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      flag_in      = flag_ff;
      rd_en_in     = rd_en_ff;
      rd_odd_in    = rd_odd_ff;
      we_even      = 1'b0;
      we_odd       = 1'b0;
      wa_even      = {wslot_ff, wlen_ff[OFF_W-1:1]};
      wa_odd       = {wslot_ff, wlen_ff[OFF_W-1:1]};
      wd_even      = data_byte;
      wd_odd       = data_byte;

      case (state_ff)
         S_CLEAR: begin
            // sweep both banks to zero
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_WORD) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            // drop the response once taken
            if (rsp_valid_ff && rsp_tready) begin
               rsp_valid_in = 1'b0;
            end
            if (accept) begin
               rsp_valid_in = 1'b1;
               status_in    = WS_STORED;
               flag_in      = 1'b0;
               rd_en_in     = 1'b0;
               rd_odd_in    = rd_off[0];
               case (act)
                  ACT_WRITE: begin
                     if (data_byte != NEWLINE_BYTE) begin
                        if (wlen_p2 >= (OFF_W + 1)'(SLOT_LEN)) begin
                           status_in = WS_DROP_BYTE;
                        end else begin
                           // store the byte at the current length
                           we_even = !wlen_ff[0];
                           we_odd  = wlen_ff[0];
                           wlen_in = wlen_p1;
                           if (wlen_ff == '0) begin
                              nz_in[wslot_ff] = (data_byte != TERM_BYTE);
                              z0_in[wslot_ff] = 1'b0;
                           end
                        end
                     end else begin
                        // store the newline and its terminator in opposite banks
                        we_even = 1'b1;
                        we_odd  = 1'b1;
                        if (wlen_ff[0]) begin
                           wd_odd  = NEWLINE_BYTE;
                           wd_even = TERM_BYTE;
                           wa_even = {wslot_ff, wlen_p1[OFF_W-1:1]};
                        end else begin
                           wd_even = NEWLINE_BYTE;
                           wd_odd  = TERM_BYTE;
                        end
                        if (wlen_ff == '0) begin
                           nz_in[wslot_ff] = 1'b1;
                           z0_in[wslot_ff] = 1'b0;
                        end
                        wlen_in = '0;
                        if (wnext == rslot_ff) begin
                           if (clobber_ff) begin
                              // drop the oldest line and push the reader on
                              nz_in[rslot_ff] = 1'b0;
                              z0_in[rslot_ff] = 1'b1;
                              if (rnext != wslot_ff) begin
                                 rslot_in = rnext;
                              end
                              wslot_in  = wnext;
                              status_in = WS_DROP_OLD;
                           end else begin
                              status_in = WS_DROP_NEW;
                           end
                        end else begin
                           wslot_in  = wnext;
                           status_in = WS_ENDED;
                        end
                     end
                  end
                  ACT_QUERY: begin
                     flag_in = nz_ff[rslot_ff];
                  end
                  ACT_SEEK: begin
                     // mark the line read and advance unless that meets the writer
                     nz_in[rslot_ff] = 1'b0;
                     z0_in[rslot_ff] = 1'b1;
                     if (rnext != wslot_ff) begin
                        rslot_in = rnext;
                        flag_in  = 1'b1;
                     end
                  end
                  ACT_READ: begin
                     rd_en_in = off_ok && !((rd_off == '0) && z0_ff[rslot_ff]);
                  end
                  default: begin
                     rd_en_in = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         wslot_ff     <= '0;
         rslot_ff     <= LAST_SLOT;
         wlen_ff      <= '0;
         nz_ff        <= '0;
         z0_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         clobber_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wslot_ff     <= wslot_in;
         rslot_ff     <= rslot_in;
         wlen_ff      <= wlen_in;
         nz_ff        <= nz_in;
         z0_ff        <= z0_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            clobber_ff <= csr_data;
         end
      end
   end

   // response payload registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      flag_ff   <= flag_in;
      rd_en_ff  <= rd_en_in;
      rd_odd_ff <= rd_odd_in;
   end

   // even bank: clear sweep, writes, registered read on accept
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         mem_even[clr_addr_ff] <= TERM_BYTE;
      end else if (accept && we_even) begin
         mem_even[wa_even] <= wd_even;
      end
      if (accept) begin
         rd_even_ff <= mem_even[ra];
      end
   end

   // odd bank: clear sweep, writes, registered read on accept
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         mem_odd[clr_addr_ff] <= TERM_BYTE;
      end else if (accept && we_odd) begin
         mem_odd[wa_odd] <= wd_odd;
      end
      if (accept) begin
         rd_odd_data_ff <= mem_odd[ra];
      end
   end

   // assemble the response item
   logic [7:0] read_data;
   assign read_data  = !rd_en_ff ? 8'd0 : (rd_odd_ff ? rd_odd_data_ff : rd_even_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, read_data, flag_ff, status_ff};

endmodule
